### hw/rtl/sha256_pkg.sv
// shared types and constants of the sha-256 hash engine
// round constants, initial hash values, word select codes, command struct
// depends on nothing
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned RoundW  = 6;
  localparam int unsigned BlkW    = 4;
  localparam int unsigned DigW    = 3;
  localparam int unsigned CountW  = 3;
  localparam int unsigned LenW    = 64;

  localparam logic [WordW-1:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] PadMark = 32'h8000_0000;

  typedef enum logic [2:0] {
    SEL_INPUT,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN_HI,
    SEL_LEN_LO
  } push_sel_e;

  typedef struct packed {
    logic            push;
    push_sel_e       push_sel;
    logic            accept;
    logic            init;
    logic            round;
    logic            update;
    logic            finish;
    logic [RoundW-1:0] rnd;
    logic [DigW-1:0]   out_idx;
  } cmd_t;

endpackage

### hw/rtl/sha256_dpath.sv
// datapath of the sha-256 hash engine: schedule window, round logic,
// chain value and bit length; driven by sha256_ctrl commands
// depends on sha256_pkg
module sha256_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sha256_pkg::cmd_t                    cmd_i,
  input  logic [sha256_pkg::WordW-1:0]        data_word_i,
  input  logic [sha256_pkg::CountW-1:0]       byte_count_i,
  input  logic                                last_word_i,
  output logic [sha256_pkg::WordW-1:0]        digest_word_o
);

  typedef logic [sha256_pkg::WordW-1:0] word_t;

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  word_t win_q [16];
  word_t win_d [16];
  word_t var_q [8];
  word_t var_d [8];
  word_t chain_q [8];
  word_t chain_d [8];
  logic [sha256_pkg::LenW-1:0] bits_q, bits_d;

  word_t in_word;
  word_t push_word;
  word_t sched_next;
  word_t t1, t2;
  logic [sha256_pkg::LenW-1:0] bits_inc;

  // final word: keep valid bytes, append the pad byte when fewer than four are valid
  always_comb begin
    if (!last_word_i || byte_count_i[2]) begin
      in_word = data_word_i;
    end else begin
      case (byte_count_i[1:0])
        2'd0:    in_word = sha256_pkg::PadMark;
        2'd1:    in_word = {data_word_i[31:24], 24'h80_0000};
        2'd2:    in_word = {data_word_i[31:16], 16'h8000};
        2'd3:    in_word = {data_word_i[31:8], 8'h80};
        default: in_word = sha256_pkg::PadMark;
      endcase
    end
  end

  always_comb begin
    if (!last_word_i || byte_count_i[2]) begin
      bits_inc = sha256_pkg::LenW'(32);
    end else begin
      bits_inc = {{(sha256_pkg::LenW-5){1'b0}}, byte_count_i[1:0], 3'b000};
    end
  end

  always_comb begin
    case (cmd_i.push_sel)
      sha256_pkg::SEL_INPUT:  push_word = in_word;
      sha256_pkg::SEL_MARK:   push_word = sha256_pkg::PadMark;
      sha256_pkg::SEL_ZERO:   push_word = '0;
      sha256_pkg::SEL_LEN_HI: push_word = bits_q[63:32];
      sha256_pkg::SEL_LEN_LO: push_word = bits_q[31:0];
      default:                push_word = '0;
    endcase
  end

  assign sched_next = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];

  assign t1 = var_q[7] + bsig1(var_q[4])
            + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
            + sha256_pkg::RoundK[cmd_i.rnd] + win_q[0];
  assign t2 = bsig0(var_q[0])
            + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_d[i] = win_q[i];
    end
    if (cmd_i.push || cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = cmd_i.push ? push_word : sched_next;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      var_d[i] = var_q[i];
    end
    if (cmd_i.init) begin
      for (int i = 0; i < 8; i++) begin
        var_d[i] = chain_q[i];
      end
    end else if (cmd_i.round) begin
      var_d[0] = t1 + t2;
      var_d[1] = var_q[0];
      var_d[2] = var_q[1];
      var_d[3] = var_q[2];
      var_d[4] = var_q[3] + t1;
      var_d[5] = var_q[4];
      var_d[6] = var_q[5];
      var_d[7] = var_q[6];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_d[i] = chain_q[i];
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = sha256_pkg::InitH[i];
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + var_q[i];
      end
    end
  end

  always_comb begin
    bits_d = bits_q;
    if (cmd_i.finish) begin
      bits_d = '0;
    end else if (cmd_i.accept) begin
      bits_d = bits_q + bits_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    var_q <= var_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha256_pkg::InitH;
      bits_q  <= '0;
    end else begin
      chain_q <= chain_d;
      bits_q  <= bits_d;
    end
  end

  assign digest_word_o = chain_q[cmd_i.out_idx];

endmodule

### hw/rtl/sha256_ctrl.sv
// controller of the sha-256 hash engine: input handshake, padding
// sequence, round sequencing and digest output
// depends on sha256_pkg
module sha256_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sha256_pkg::CountW-1:0]     byte_count_i,
  input  logic                              last_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sha256_pkg::DigW-1:0]       word_index_o,
  output logic                              last_result_o,
  output sha256_pkg::cmd_t                  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD    = 3'd1;
  localparam logic [2:0] ST_INIT   = 3'd2;
  localparam logic [2:0] ST_ROUND  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  localparam logic [sha256_pkg::BlkW-1:0]   PosLast   = '1;
  localparam logic [sha256_pkg::BlkW-1:0]   PosLenHi  = PosLast - 1'b1;
  localparam logic [sha256_pkg::RoundW-1:0] RoundLast = '1;
  localparam logic [sha256_pkg::DigW-1:0]   IdxLast   = '1;

  logic [2:0]                      state_q, state_d;
  logic [sha256_pkg::BlkW-1:0]     pos_q, pos_d;
  logic [sha256_pkg::RoundW-1:0]   rnd_q, rnd_d;
  logic [sha256_pkg::DigW-1:0]     idx_q, idx_d;
  logic                            mark_q, mark_d;
  logic                            pad_q, pad_d;
  logic                            len_q, len_d;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    mark_d  = mark_q;
    pad_d   = pad_q;
    len_d   = len_q;

    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    cmd_o          = '0;
    cmd_o.push_sel = sha256_pkg::SEL_INPUT;
    cmd_o.rnd      = rnd_q;
    cmd_o.out_idx  = idx_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.push   = 1'b1;
          cmd_o.accept = 1'b1;
          pos_d        = pos_q + 1'b1;
          mark_d       = last_word_i & byte_count_i[2];
          pad_d        = last_word_i;
          if (pos_q == PosLast) begin
            state_d = ST_INIT;
          end else if (last_word_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.push = 1'b1;
        pos_d      = pos_q + 1'b1;
        if (mark_q) begin
          cmd_o.push_sel = sha256_pkg::SEL_MARK;
          mark_d         = 1'b0;
        end else if (pos_q == PosLenHi) begin
          cmd_o.push_sel = sha256_pkg::SEL_LEN_HI;
          len_d          = 1'b1;
        end else if (pos_q == PosLast && len_q) begin
          cmd_o.push_sel = sha256_pkg::SEL_LEN_LO;
        end else begin
          cmd_o.push_sel = sha256_pkg::SEL_ZERO;
        end
        if (pos_q == PosLast) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        rnd_d      = '0;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 1'b1;
        if (rnd_q == RoundLast) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (len_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == IdxLast) begin
            cmd_o.finish = 1'b1;
            pos_d        = '0;
            pad_d        = 1'b0;
            len_d        = 1'b0;
            mark_d       = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign word_index_o  = idx_q;
  assign last_result_o = (idx_q == IdxLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      mark_q  <= 1'b0;
      pad_q   <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      mark_q  <= mark_d;
      pad_q   <= pad_d;
      len_q   <= len_d;
    end
  end

endmodule

### hw/rtl/sha256_hash_engine_unit.sv
// top level of the sha-256 hash engine: controller plus datapath
// depends on sha256_pkg, sha256_ctrl, sha256_dpath
//
// Takes a byte message as big-endian 32-bit words and returns the eight
// SHA-256 digest words, index 0 first, after the word marked last. One item
// is accepted per cycle until 16 words fill a block; the block is then
// compressed (load, 64 rounds at one round per cycle, chain update) and no
// item is accepted meanwhile. After the last word the engine pushes the
// padding and length words at one per cycle, pausing while a filled block
// is compressed (up to 15 words, or up to 18 when a second block is needed),
// runs one or two compressions and then presents the digest, one word per
// cycle while the consumer is ready.
module sha256_hash_engine_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sha256_pkg::WordW-1:0]      data_word_i,
  input  logic [sha256_pkg::CountW-1:0]     byte_count_i,
  input  logic                              last_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sha256_pkg::WordW-1:0]      digest_word_o,
  output logic [sha256_pkg::DigW-1:0]       word_index_o,
  output logic                              last_result_o
);

  sha256_pkg::cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_count_i  (byte_count_i),
    .last_word_i   (last_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_index_o  (word_index_o),
    .last_result_o (last_result_o),
    .cmd_o         (cmd)
  );

  sha256_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_word_i   (data_word_i),
    .byte_count_i  (byte_count_i),
    .last_word_i   (last_word_i),
    .digest_word_o (digest_word_o)
  );

endmodule
